@@ rtl/kvt_pkg.sv @@
// Shared types and constants for the key/value table.
`timescale 1ns / 1ps

package kvt_pkg;

  localparam int DATA_W       = 32;
  localparam int CNT_OUT_W    = 5;
  localparam int DEF_CAPACITY = 16;
  localparam logic [DATA_W-1:0] NULL_RESET = 32'hFFFE_4DF9;  // -111111

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } kvt_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_WB
  } kvt_state_t;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } kvt_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     hit;
    logic                     full_reject;
    logic [CNT_OUT_W-1:0]     entry_count;
  } kvt_out_t;

  // Broadcast control from the sequencer to every slot cell
  typedef struct packed {
    logic    cmp;        // compare phase
    logic    wb;         // write-back phase
    kvt_op_t op;
    logic    hit;        // some live slot matched
    logic    append_ok;  // add of a new key fits
  } kvt_ctl_t;

endpackage

@@ rtl/kvt_cell.sv @@
// One slot of the table: holds a pair, compares it, and updates it on write-back.
`timescale 1ns / 1ps

module kvt_cell #(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  logic                              clk,
  input  kvt_pkg::kvt_ctl_t                 ctl,
  input  logic [CNT_W-1:0]                  count,
  input  logic signed [kvt_pkg::DATA_W-1:0] in_key,
  input  logic signed [kvt_pkg::DATA_W-1:0] in_value,
  input  logic signed [kvt_pkg::DATA_W-1:0] last_key,
  input  logic signed [kvt_pkg::DATA_W-1:0] last_value,
  input  logic                              next_live,
  output logic                              live,
  output logic                              match_r,
  output logic                              last_r,
  output logic signed [kvt_pkg::DATA_W-1:0] key_r,
  output logic signed [kvt_pkg::DATA_W-1:0] value_r
);
  import kvt_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic                     match_nxt;
  logic                     last_nxt;
  logic signed [DATA_W-1:0] key_nxt;
  logic signed [DATA_W-1:0] value_nxt;

  // Slot is live when it sits below the pair count
  assign live = (MY_IDX < count);

  // Compare phase: latch match and whether this is the tail slot
  always_comb begin
    match_nxt = match_r;
    last_nxt  = last_r;
    if (ctl.cmp) begin
      match_nxt = live && (key_r == in_key);
      last_nxt  = live && !next_live;
    end
  end

  // Write-back phase: replace, append or fill the hole from the tail
  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ctl.wb) begin
      case (ctl.op)
        OP_ADD: begin
          if (ctl.hit && match_r) begin
            value_nxt = in_value;
          end else if (ctl.append_ok && (MY_IDX == count)) begin
            key_nxt   = in_key;
            value_nxt = in_value;
          end
        end
        OP_REMOVE: begin
          if (ctl.hit && match_r) begin
            key_nxt   = last_key;
            value_nxt = last_value;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    match_r <= match_nxt;
    last_r  <= last_nxt;
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule

@@ rtl/key_value_table.sv @@
// Top level of the key/value table: sequencer, row of slot cells, result register.
// The result strobe is registered after the compare and write-back states.
// A new transaction is taken in idle or write-back, never during the cells' compare.
// busy is high only in the compare cycle; the receiver cannot stall the result strobe.
// Reset (synchronous, rst_n low): pair count zero, null value -111111; slots not cleared.
`timescale 1ns / 1ps

module key_value_table #(
  parameter int CAPACITY = kvt_pkg::DEF_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  kvt_pkg::kvt_in_t                  in_data,
  output logic                              out_valid,
  output kvt_pkg::kvt_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic signed [kvt_pkg::DATA_W-1:0] cfg_data
);
  import kvt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  kvt_state_t               state_r, state_nxt;
  kvt_op_t                  op_r;
  logic signed [DATA_W-1:0] key_r;
  logic signed [DATA_W-1:0] value_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [DATA_W-1:0] null_r;
  logic                     out_valid_r;
  kvt_out_t                 out_r, out_nxt;
  logic                     accept;

  kvt_ctl_t                 ctl;
  logic [CAPACITY-1:0]      live;
  logic [CAPACITY-1:0]      match;
  logic [CAPACITY-1:0]      tail;
  logic signed [DATA_W-1:0] slot_key   [CAPACITY];
  logic signed [DATA_W-1:0] slot_value [CAPACITY];
  logic signed [DATA_W-1:0] found_value;
  logic signed [DATA_W-1:0] last_key;
  logic signed [DATA_W-1:0] last_value;
  logic                     any_hit;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_WB;
      ST_WB:   state_nxt = start ? ST_CMP : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    busy      = 1'b0;
    cfg_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: cfg_ready = 1'b1;
      ST_CMP:  busy = 1'b1;
      ST_WB:   busy = 1'b0;
      default: busy = 1'b1;
    endcase
  end

  assign accept = start && !busy;

  // Gather the matching slot and the tail slot
  always_comb begin
    found_value = '0;
    last_key    = '0;
    last_value  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found_value = found_value | (match[i] ? slot_value[i] : '0);
      last_key    = last_key    | (tail[i]  ? slot_key[i]   : '0);
      last_value  = last_value  | (tail[i]  ? slot_value[i] : '0);
    end
  end

  assign any_hit = (|match) && (op_r != OP_NOP);

  // Broadcast control
  always_comb begin
    ctl.cmp       = (state_r == ST_CMP);
    ctl.wb        = (state_r == ST_WB);
    ctl.op        = op_r;
    ctl.hit       = any_hit;
    ctl.append_ok = (op_r == OP_ADD) && !any_hit && (count_r < CAP_CNT);
  end

  // Row of slot cells, each linked to its upper neighbor's live flag
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic nb_live;
    if (g == CAPACITY - 1) begin : g_end
      assign nb_live = 1'b0;
    end else begin : g_mid
      assign nb_live = live[g+1];
    end
    kvt_cell #(
      .CNT_W (CNT_W),
      .IDX   (g)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .in_key     (key_r),
      .in_value   (value_r),
      .last_key   (last_key),
      .last_value (last_value),
      .next_live  (nb_live),
      .live       (live[g]),
      .match_r    (match[g]),
      .last_r     (tail[g]),
      .key_r      (slot_key[g]),
      .value_r    (slot_value[g])
    );
  end

  // Write-back result and new count
  always_comb begin
    count_nxt = count_r;
    if (ctl.append_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if ((op_r == OP_REMOVE) && any_hit) begin
      count_nxt = count_r - CNT_W'(1);
    end
    out_nxt.result_value = any_hit ? found_value : null_r;
    out_nxt.hit          = any_hit;
    out_nxt.full_reject  = (op_r == OP_ADD) && !any_hit && (count_r == CAP_CNT);
    out_nxt.entry_count  = CNT_OUT_W'(count_nxt);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      null_r      <= NULL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_WB);
      if (state_r == ST_WB) begin
        count_r <= count_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        null_r <= cfg_data;
      end
    end
  end

  // Transaction and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= kvt_op_t'(in_data.operation);
      key_r   <= in_data.key;
      value_r <= in_data.value;
    end
    if (state_r == ST_WB) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
